### src/rld_pkg.sv
// Shared definitions for the run-length decoder: field widths, header bit
// masks, run kinds and the packed result record. No dependencies.
package rld_pkg;

  // Field widths
  localparam int unsigned ByteW   = 8;
  localparam int unsigned SizeW   = 26;
  localparam int unsigned PosW    = 32;
  localparam int unsigned CapW    = 32;
  localparam int unsigned OutDataW = 40;  // value + length, padded to bytes

  // Header byte masks
  localparam logic [7:0] SizeMask  = 8'h1F;
  localparam logic [7:0] ExtFlag   = 8'h20;
  localparam logic [7:0] ExtMask   = 8'h7F;
  localparam logic [7:0] MoreFlag  = 8'h80;
  localparam logic [7:0] OnesValue = 8'hFF;

  // Capacity after reset
  localparam logic [CapW-1:0] CapReset = 32'hFFFF_FFFF;

  // Run kinds carried in header bits 7..6
  localparam logic [1:0] KindZero    = 2'd0;
  localparam logic [1:0] KindOnes    = 2'd1;
  localparam logic [1:0] KindByte    = 2'd2;
  localparam logic [1:0] KindLiteral = 2'd3;

  // One result as it leaves the decoder
  typedef struct packed {
    logic             corrupt;
    logic             blob_end;
    logic [SizeW-1:0] run_length;
    logic [ByteW-1:0] run_value;
  } result_t;

endpackage

### src/run_length_decoder.sv
// Run-length decoder top level: input register, header/run decode logic
// and result register. Depends on rld_pkg.
//
// Takes one coded byte per transfer on the slave stream (tlast marks the last
// byte of a blob) and returns one run per result on the master stream: value,
// length and the sticky corrupt flag, with tlast on the result of the last
// byte. Runs are reported, not expanded. The block sustains one byte per
// clock cycle while the run sink keeps up. A byte is decoded from the input
// register, and its run is loaded into the result register when the decode
// stage advances; the run is transferred from that register.
// The longest decode path is a 33-bit add and compare against the capacity.
// A run waiting in the result register stalls the input register, header
// bytes included. Header bytes produce a result only when they complete a
// zero or ones run, fail or are last. The capacity register is written on
// the cfg channel, which always accepts; write it only while the block is
// idle. After reset the capacity is 0xFFFFFFFF and no clearing pass is needed.
module run_length_decoder (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // Capacity write channel
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [rld_pkg::CapW-1:0]    cfg_data_i,
  // Coded byte stream
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [7:0]                  s_axis_tdata,   // [7:0] in_byte
  input  logic                        s_axis_tlast,   // is_last
  // Run stream
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [rld_pkg::OutDataW-1:0] m_axis_tdata,  // [7:0] run_value,
                                                      // [33:8] run_length,
                                                      // [39:34] zero
  output logic                        m_axis_tlast,   // blob_end
  output logic                        m_axis_tuser    // corrupt
);

  typedef enum logic [2:0] {
    PhHeader,
    PhExt1,
    PhExt2,
    PhExt3,
    PhLiteral,
    PhValue,
    PhPass,
    PhDrop
  } phase_e;

  // Configuration
  logic [rld_pkg::CapW-1:0] cap_q;

  // Input register
  logic                     in_valid_q;
  logic [7:0]               in_byte_q;
  logic                     in_last_q;

  // Decoder state
  phase_e                    phase_q, phase_d;
  logic [1:0]                kind_q, kind_d;
  logic [rld_pkg::SizeW-1:0] pend_q, pend_d;
  logic [rld_pkg::PosW-1:0]  pos_q, pos_d;
  logic                      err_q, err_d;

  // Result register
  logic                      out_valid_q;
  rld_pkg::result_t          out_q, res_d;
  logic                      have_res;

  // Shared adder
  logic [rld_pkg::SizeW-1:0] add_op;
  logic [rld_pkg::PosW:0]    sum;
  logic                      over_cap;
  logic [rld_pkg::SizeW-1:0] size_cand;

  logic                      advance;

  // Handshakes
  assign cfg_ready_o   = 1'b1;
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  // Capacity register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= rld_pkg::CapReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      cap_q <= cfg_data_i;
    end
  end

  // Hold the incoming byte until the decode stage takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
  end

  // Size seen if this byte finishes a header
  always_comb begin
    if (phase_q == PhHeader) begin
      size_cand = rld_pkg::SizeW'(in_byte_q & rld_pkg::SizeMask);
    end else begin
      size_cand = {pend_q[rld_pkg::SizeW-8:0], in_byte_q[6:0]};
    end
  end

  // Pick the adder operand: header size, one byte, or the pending run
  always_comb begin
    case (phase_q)
      PhLiteral, PhPass: add_op = rld_pkg::SizeW'(1);
      PhValue:           add_op = pend_q;
      default:           add_op = size_cand;
    endcase
  end

  assign sum      = {1'b0, pos_q} + (rld_pkg::PosW + 1)'(add_op);
  assign over_cap = sum > {1'b0, cap_q};

  // Decode one byte
  always_comb begin
    logic hdr_done;
    logic fail;

    phase_d  = phase_q;
    kind_d   = kind_q;
    pend_d   = pend_q;
    pos_d    = pos_q;
    err_d    = err_q;
    have_res = 1'b0;
    res_d    = '0;
    hdr_done = 1'b0;
    fail     = 1'b0;

    case (phase_q)
      PhHeader: begin
        kind_d = in_byte_q[7:6];
        pend_d = size_cand;
        if ((in_byte_q & rld_pkg::ExtFlag) == 8'h00) begin
          hdr_done = 1'b1;
        end else begin
          phase_d = PhExt1;
        end
      end
      PhExt1, PhExt2, PhExt3: begin
        pend_d = size_cand;
        if ((in_byte_q & rld_pkg::MoreFlag) == 8'h00) begin
          hdr_done = 1'b1;
        end else if (phase_q == PhExt3) begin
          fail = 1'b1;
        end else if (phase_q == PhExt1) begin
          phase_d = PhExt2;
        end else begin
          phase_d = PhExt3;
        end
      end
      PhLiteral: begin
        have_res           = 1'b1;
        res_d.run_value    = in_byte_q;
        res_d.run_length   = rld_pkg::SizeW'(1);
        pos_d              = sum[rld_pkg::PosW-1:0];
        pend_d             = pend_q - rld_pkg::SizeW'(1);
        if (pend_d == '0) begin
          phase_d = PhHeader;
        end
      end
      PhValue: begin
        have_res           = 1'b1;
        res_d.run_value    = in_byte_q;
        res_d.run_length   = pend_q;
        pos_d              = sum[rld_pkg::PosW-1:0];
        phase_d            = PhHeader;
      end
      PhPass: begin
        if (over_cap) begin
          fail = 1'b1;
        end else begin
          have_res         = 1'b1;
          res_d.run_value  = in_byte_q;
          res_d.run_length = rld_pkg::SizeW'(1);
          pos_d            = sum[rld_pkg::PosW-1:0];
        end
      end
      default: begin
        // discard the rest of a corrupt blob
      end
    endcase

    // Finish a header: capacity check, then act on the run kind
    if (hdr_done) begin
      if (over_cap) begin
        fail = 1'b1;
      end else begin
        case (kind_d)
          rld_pkg::KindLiteral: begin
            phase_d = (size_cand == '0) ? PhPass : PhLiteral;
          end
          rld_pkg::KindZero: begin
            have_res         = 1'b1;
            res_d.run_length = size_cand;
            pos_d            = sum[rld_pkg::PosW-1:0];
            phase_d          = PhHeader;
          end
          rld_pkg::KindOnes: begin
            have_res         = 1'b1;
            res_d.run_value  = rld_pkg::OnesValue;
            res_d.run_length = size_cand;
            pos_d            = sum[rld_pkg::PosW-1:0];
            phase_d          = PhHeader;
          end
          default: begin
            phase_d = PhValue;
          end
        endcase
      end
    end

    // Error: status-only result, drop the rest of the blob
    if (fail) begin
      err_d    = 1'b1;
      phase_d  = PhDrop;
      have_res = 1'b1;
      res_d.run_value  = '0;
      res_d.run_length = '0;
    end

    res_d.blob_end = in_last_q;
    res_d.corrupt  = err_d;

    // Last byte always reports, then the blob state clears
    if (in_last_q) begin
      have_res = 1'b1;
      phase_d  = PhHeader;
      kind_d   = rld_pkg::KindZero;
      pend_d   = '0;
      pos_d    = '0;
      err_d    = 1'b0;
    end
  end

  // Advance decoder state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhHeader;
      kind_q  <= rld_pkg::KindZero;
      pend_q  <= '0;
      pos_q   <= '0;
      err_q   <= 1'b0;
    end else if (advance) begin
      phase_q <= phase_d;
      kind_q  <= kind_d;
      pend_q  <= pend_d;
      pos_q   <= pos_d;
      err_q   <= err_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && have_res) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && have_res) begin
      out_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(rld_pkg::OutDataW - rld_pkg::SizeW - rld_pkg::ByteW){1'b0}},
                          out_q.run_length, out_q.run_value};
  assign m_axis_tlast  = out_q.blob_end;
  assign m_axis_tuser  = out_q.corrupt;

  // An error always parks the decoder in the discard phase
  a_err_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    err_q |-> (phase_q == PhDrop))
    else $error("error flag set outside discard phase");

  // The last byte of a blob leaves clean state behind
  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && in_last_q) |=> (phase_q == PhHeader && pos_q == '0 && !err_q))
    else $error("blob state not cleared after last byte");

  // A corrupt result before the end of the blob is the status-only one
  a_corrupt_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tlast && m_axis_tuser) |-> (out_q.run_length == '0))
    else $error("corrupt mid-blob result carries a run");

endmodule

### tb/rld_run_checker.sv
`timescale 1ns / 100ps
// Checker for the run-length decoder: watches the capacity, byte and run
// channels, predicts each run and compares it field by field. Needs rld_pkg.
module rld_run_checker
  import rld_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_i,
  input  logic [CapW-1:0]     cfg_data_i,
  input  logic                s_tvalid_i,
  input  logic                s_tready_i,
  input  logic [7:0]          s_tdata_i,
  input  logic                s_tlast_i,
  input  logic                m_tvalid_i,
  input  logic                m_tready_i,
  input  logic [OutDataW-1:0] m_tdata_i,
  input  logic                m_tlast_i,
  input  logic                m_tuser_i,
  output int                  mismatches_o,
  output int                  pending_o,
  output int                  runs_checked_o,
  output int                  corrupt_runs_o
);

  // Decoder position within the coded blob
  typedef enum logic [2:0] {
    StHeader, StExt1, StExt2, StExt3, StLiteral, StByteValue, StPassThrough, StDiscard
  } dec_state_e;

  dec_state_e       dec_state;
  logic [1:0]       run_kind;
  logic [SizeW-1:0] size_left;
  logic [32:0]      out_pos;
  logic             blob_bad;
  logic [CapW-1:0]  capacity;

  logic             run_ready;
  result_t          next_run;
  result_t          runs_due[$];

  // Print one line per mismatch and count it
  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    $display("[%0t] run %0d: %s got 0x%0h, want 0x%0h", $realtime, runs_checked_o, what,
             got, want);
    mismatches_o++;
  endtask

  function automatic void emit_run(input logic [7:0] value, input logic [SizeW-1:0] len);
    run_ready = 1'b1;
    next_run.run_value = value;
    next_run.run_length = len;
  endfunction

  // Flag the blob and drop its remaining bytes
  function automatic void mark_corrupt();
    blob_bad = 1'b1;
    dec_state = StDiscard;
    emit_run(8'h00, '0);
  endfunction

  function automatic void clear_blob();
    dec_state = StHeader;
    run_kind = KindZero;
    size_left = '0;
    out_pos = '0;
    blob_bad = 1'b0;
  endfunction

  // Header complete: check room, then report the run or wait for its bytes
  function automatic void close_header(input logic [SizeW-1:0] size);
    logic [32:0] needed;
    size_left = size;
    needed = out_pos + 33'(size);
    if (needed > {1'b0, capacity}) begin
      mark_corrupt();
    end else begin
      case (run_kind)
        KindLiteral: dec_state = (size == '0) ? StPassThrough : StLiteral;
        KindZero: begin
          emit_run(8'h00, size);
          out_pos = out_pos + 33'(size);
          dec_state = StHeader;
        end
        KindOnes: begin
          emit_run(OnesValue, size);
          out_pos = out_pos + 33'(size);
          dec_state = StHeader;
        end
        default: dec_state = StByteValue;
      endcase
    end
  endfunction

  // Advance the decoder by one coded byte and queue the run it gives
  function automatic void decode_byte(input logic [7:0] b, input logic last);
    logic [32:0] needed;
    run_ready = 1'b0;
    next_run = '0;
    case (dec_state)
      StHeader: begin
        run_kind = b[7:6];
        size_left = SizeW'(b & SizeMask);
        if ((b & ExtFlag) == 8'h00) close_header(size_left);
        else dec_state = StExt1;
      end
      StExt1, StExt2, StExt3: begin
        size_left = {size_left[SizeW-8:0], b[6:0] & ExtMask[6:0]};
        if ((b & MoreFlag) == 8'h00) close_header(size_left);
        else if (dec_state == StExt3) mark_corrupt();
        else dec_state = (dec_state == StExt1) ? StExt2 : StExt3;
      end
      StLiteral: begin
        emit_run(b, SizeW'(1));
        out_pos = out_pos + 33'(1);
        size_left = size_left - SizeW'(1);
        if (size_left == '0) dec_state = StHeader;
      end
      StByteValue: begin
        emit_run(b, size_left);
        out_pos = out_pos + 33'(size_left);
        dec_state = StHeader;
      end
      StPassThrough: begin
        needed = out_pos + 33'(1);
        if (needed > {1'b0, capacity}) begin
          mark_corrupt();
        end else begin
          emit_run(b, SizeW'(1));
          out_pos = out_pos + 33'(1);
        end
      end
      default: ;
    endcase
    if (run_ready || last) begin
      next_run.blob_end = last;
      next_run.corrupt = blob_bad;
      runs_due.push_back(next_run);
    end
    if (last) clear_blob();
  endfunction

  // Compare one run transfer with the oldest prediction
  task automatic check_run();
    result_t got;
    result_t want;
    logic [OutDataW-ByteW-SizeW-1:0] pad;
    got.run_value = m_tdata_i[ByteW-1:0];
    got.run_length = m_tdata_i[ByteW+SizeW-1:ByteW];
    got.blob_end = m_tlast_i;
    got.corrupt = m_tuser_i;
    pad = m_tdata_i[OutDataW-1:ByteW+SizeW];
    if (got.corrupt) corrupt_runs_o++;
    if (pad != '0) report_mismatch("padding", pad, 0);
    if (runs_due.size() == 0) begin
      report_mismatch("run with none due, data", m_tdata_i, 0);
    end else begin
      want = runs_due.pop_front();
      if (got.run_value != want.run_value)
        report_mismatch("run_value", got.run_value, want.run_value);
      if (got.run_length != want.run_length)
        report_mismatch("run_length", got.run_length, want.run_length);
      if (got.blob_end != want.blob_end)
        report_mismatch("blob_end", got.blob_end, want.blob_end);
      if (got.corrupt != want.corrupt)
        report_mismatch("corrupt", got.corrupt, want.corrupt);
    end
    runs_checked_o++;
  endtask

  // Follow every transfer at the clock edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_blob();
      capacity = CapReset;
      runs_due.delete();
      mismatches_o = 0;
      runs_checked_o = 0;
      corrupt_runs_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) capacity = cfg_data_i;
      if (s_tvalid_i && s_tready_i) decode_byte(s_tdata_i, s_tlast_i);
      if (m_tvalid_i && m_tready_i) check_run();
    end
    pending_o = runs_due.size();
  end

endmodule

### tb/run_length_decoder_tb.sv
`timescale 1ns / 100ps
// Top of the run-length decoder testbench: clock, reset, coded blob stimulus,
// run sink and verdict. Needs rld_pkg, run_length_decoder and rld_run_checker.
module run_length_decoder_tb;
  import rld_pkg::*;

  localparam int WatchLimit  = 2000;
  localparam int LongHold    = 300;
  localparam int DrainCycles = 4;
  localparam int EndCycles   = 8;
  localparam int PhaseBytes  = 285;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CapW-1:0]     cfg_data = '0;
  logic                s_valid = 1'b0;
  logic                s_ready;
  logic [7:0]          s_data = '0;
  logic                s_last = 1'b0;
  logic                m_valid;
  logic                m_ready = 1'b0;
  logic [OutDataW-1:0] m_data;
  logic                m_last;
  logic                m_user;

  int mismatches;
  int pending;
  int runs_checked;
  int corrupt_runs;

  logic [7:0] coded[$];
  int bytes_sent = 0;
  int blobs_sent = 0;
  int cap_writes = 0;
  int hold_asked = 0;
  int hold_served = 0;
  int idle_cycles = 0;

  run_length_decoder dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_data_i    (cfg_data),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_ready),
    .s_axis_tdata  (s_data),
    .s_axis_tlast  (s_last),
    .m_axis_tvalid (m_valid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_data),
    .m_axis_tlast  (m_last),
    .m_axis_tuser  (m_user)
  );

  rld_run_checker u_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_i    (cfg_ready),
    .cfg_data_i     (cfg_data),
    .s_tvalid_i     (s_valid),
    .s_tready_i     (s_ready),
    .s_tdata_i      (s_data),
    .s_tlast_i      (s_last),
    .m_tvalid_i     (m_valid),
    .m_tready_i     (m_ready),
    .m_tdata_i      (m_data),
    .m_tlast_i      (m_last),
    .m_tuser_i      (m_user),
    .mismatches_o   (mismatches),
    .pending_o      (pending),
    .runs_checked_o (runs_checked),
    .corrupt_runs_o (corrupt_runs)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // End the run when no transfer happens for too long
  always @(posedge clk) begin
    if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WatchLimit) begin
      $display("timeout: no transfer for %0d cycles, %0d runs outstanding",
               idle_cycles, pending);
      $display("FAILURE");
      $finish;
    end
  end

  // Run sink: random stalls, fast stretches and one long hold on request
  initial begin : run_sink
    int gap;
    int taken;
    bit rx_fast;
    logic seen;
    taken = 0;
    rx_fast = 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (hold_asked != hold_served) begin
        hold_served = hold_asked;
        gap = LongHold;
      end else begin
        gap = rx_fast ? 0 : $urandom_range(0, 9);
      end
      if (gap > 0) begin
        m_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_ready <= 1'b1;
      do begin
        @(negedge clk);
        seen = m_valid;
        @(posedge clk);
      end while (!seen);
      taken++;
      if (taken % 40 == 0) rx_fast = ($urandom_range(0, 3) == 0);
    end
  end

  // Offer one coded byte and hold it until the transfer
  task automatic send_byte(input logic [7:0] b, input logic last, input bit fast);
    int gap;
    logic seen;
    gap = fast ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_valid <= 1'b1;
    s_data <= b;
    s_last <= last;
    do begin
      @(negedge clk);
      seen = s_ready;
      @(posedge clk);
    end while (!seen);
    bytes_sent++;
  endtask

  task automatic send_coded(input bit fast);
    foreach (coded[i]) send_byte(coded[i], i == coded.size() - 1, fast);
    blobs_sent++;
  endtask

  // Wait until every predicted run has been taken
  task automatic wait_drained();
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CapW-1:0] value);
    logic seen;
    s_valid <= 1'b0;
    wait_drained();
    repeat (DrainCycles) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do begin
      @(negedge clk);
      seen = cfg_ready;
      @(posedge clk);
    end while (!seen);
    cfg_valid <= 1'b0;
    cap_writes++;
  endtask

  // Append a header with the given number of continuation bytes
  function automatic void put_header(input logic [1:0] kind, input logic [SizeW-1:0] size,
                                     input int n_ext, input bit overflow);
    logic [SizeW-1:0] part;
    part = size >> (7 * n_ext);
    coded.push_back({kind, n_ext != 0, part[4:0]});
    for (int i = 0; i < n_ext; i++) begin
      part = size >> (7 * (n_ext - 1 - i));
      coded.push_back({(i < n_ext - 1) || overflow, part[6:0]});
    end
  endfunction

  function automatic int pick_ext_count();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) return 0;
    if (pick < 80) return 1;
    if (pick < 93) return 2;
    return 3;
  endfunction

  function automatic logic [SizeW-1:0] pick_size(input int n_ext);
    logic [SizeW-1:0] v;
    v = SizeW'($urandom);
    return v >> (21 - 7 * n_ext);
  endfunction

  // Append one well-formed run, or now and then a header overflow
  function automatic void put_run();
    int pick;
    int n_ext;
    int len;
    pick = $urandom_range(0, 99);
    n_ext = pick_ext_count();
    if (pick < 25) begin
      put_header(KindZero, pick_size(n_ext), n_ext, 1'b0);
    end else if (pick < 45) begin
      put_header(KindOnes, pick_size(n_ext), n_ext, 1'b0);
    end else if (pick < 65) begin
      put_header(KindByte, pick_size(n_ext), n_ext, 1'b0);
      coded.push_back(8'($urandom_range(0, 255)));
    end else if (pick < 94) begin
      len = $urandom_range(1, 8);
      put_header(KindLiteral, SizeW'(len), $urandom_range(0, 1), 1'b0);
      repeat (len) coded.push_back(8'($urandom_range(0, 255)));
    end else begin
      put_header(2'($urandom_range(0, 3)), pick_size(3), 3, 1'b1);
    end
  endfunction

  // Build a random blob: mostly valid runs, some pass-through tails,
  // truncated endings and plain noise
  function automatic void build_blob();
    int pick;
    int n;
    coded.delete();
    pick = $urandom_range(0, 99);
    if (pick < 6) begin
      repeat ($urandom_range(1, 10)) coded.push_back(8'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(1, 6)) put_run();
      if (pick < 18) begin
        put_header(KindLiteral, '0, $urandom_range(0, 1), 1'b0);
        repeat ($urandom_range(0, 12)) coded.push_back(8'($urandom_range(0, 255)));
      end
      if (pick >= 90 && coded.size() > 1) begin
        n = $urandom_range(1, coded.size() - 1);
        repeat (n) void'(coded.pop_back());
      end
    end
  endfunction

  task automatic run_phase(input int target);
    int start;
    start = bytes_sent;
    while (bytes_sent - start < target) begin
      build_blob();
      send_coded($urandom_range(0, 4) == 0);
    end
  endtask

  initial begin : stimulus
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: every run kind, size extremes, longest header, zero-length
    // byte run, truncated header, header overflow, pass-through, cut literal
    coded = '{8'h00, 8'h5F, 8'h81, 8'hA5, 8'hC2, 8'h00, 8'hFF,
              8'h3F, 8'hFF, 8'hFF, 8'h7F, 8'h60};
    send_coded(1'b0);
    coded = '{8'h20, 8'h80, 8'h80, 8'h80, 8'h12, 8'h00};
    send_coded(1'b0);
    coded = '{8'hC0, 8'h11, 8'hEE};
    send_coded(1'b1);
    coded = '{8'h80, 8'h33, 8'h85};
    send_coded(1'b0);
    coded = '{8'hC3, 8'h01};
    send_coded(1'b0);

    // Fill the block while the sink holds off, then let it drain
    hold_asked++;
    coded.delete();
    coded.push_back({KindLiteral, 6'd0});
    repeat (40) coded.push_back(8'($urandom_range(0, 255)));
    send_coded(1'b1);
    s_valid <= 1'b0;
    wait_drained();

    // Random blobs under several capacities
    run_phase(PhaseBytes);
    write_capacity('0);
    run_phase(PhaseBytes);
    write_capacity(CapW'($urandom_range(1, 40)));
    run_phase(PhaseBytes);
    write_capacity(CapW'($urandom));
    run_phase(PhaseBytes);
    write_capacity(CapReset);
    run_phase(PhaseBytes);

    s_valid <= 1'b0;
    wait_drained();
    repeat (EndCycles) @(posedge clk);
    $display("Sent %0d coded bytes in %0d blobs, %0d capacity writes plus reset value",
             bytes_sent, blobs_sent, cap_writes);
    $display("Checked %0d runs, %0d of them flagged corrupt", runs_checked, corrupt_runs);
    if (mismatches == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### run_length_decoder.f
src/rld_pkg.sv
src/run_length_decoder.sv
tb/rld_run_checker.sv
tb/run_length_decoder_tb.sv
